// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only while reset is low.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked only while reset is low.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also runs through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/rcef_pkg.sv -----
// Types and constants for the Roberts cross edge filter.
`timescale 1ns / 1ps
package rcef_pkg;

   localparam int PIX_W       = 8;
   localparam int DIM_W       = 12;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int FIFO_CNT_W  = 4;

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic             last_of_run;
      logic             end_of_frame;
   } rsp_type;

   // Per-pixel flags decided at acceptance time.
   typedef struct packed {
      logic has_left;   // result for column j-1 of the upper row
      logic has_edge;   // replicated edge-column result
      logic last_row;
   } ctl_type;

   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      abs_diff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- hw/rtl/rcef_line_buf.sv -----
// Previous-row line store: read-before-write synchronous memory.
`timescale 1ns / 1ps
module rcef_line_buf #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [rcef_pkg::PIX_W-1:0]  wr_data,
   output logic [rcef_pkg::PIX_W-1:0]  rd_data
);

   logic [rcef_pkg::PIX_W-1:0] mem [DEPTH];
   logic [rcef_pkg::PIX_W-1:0] rd_data_ff;

   // Same-address read and write: the read returns the old row's pixel.
   always_ff @(posedge clock) begin
      if (enable) begin
         rd_data_ff <= mem[addr];
         mem[addr]  <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/rcef_grad.sv -----
// Gradient stage: 2x2 window registers and Roberts cross arithmetic.
`timescale 1ns / 1ps
module rcef_grad (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [rcef_pkg::PIX_W-1:0]  in_pix,
   input  rcef_pkg::ctl_type           in_ctl,
   input  logic [rcef_pkg::PIX_W-1:0]  up_pix,
   output logic                        busy,
   output rcef_pkg::push_type          push
);

   logic                        s1_valid_ff, s1_valid_in;
   logic [rcef_pkg::PIX_W-1:0]  s1_pix_ff;
   rcef_pkg::ctl_type           s1_ctl_ff;
   logic [rcef_pkg::PIX_W-1:0]  ul_ff, ul_in;
   logic [rcef_pkg::PIX_W-1:0]  ll_ff, ll_in;

   logic [rcef_pkg::PIX_W-1:0]  diag_a, diag_b, vert;
   logic [rcef_pkg::PIX_W:0]    sum_left;
   rcef_pkg::rsp_type           res_left, res_edge;

   assign s1_valid_in = in_valid;
   assign ul_in = s1_valid_ff ? up_pix    : ul_ff;
   assign ll_in = s1_valid_ff ? s1_pix_ff : ll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         ul_ff       <= '0;
         ll_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         ul_ff       <= ul_in;
         ll_ff       <= ll_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_pix_ff <= in_pix;
         s1_ctl_ff <= in_ctl;
      end
   end

   always_comb begin
      diag_a   = rcef_pkg::abs_diff(ul_ff, s1_pix_ff);
      diag_b   = rcef_pkg::abs_diff(up_pix, ll_ff);
      vert     = rcef_pkg::abs_diff(up_pix, s1_pix_ff);
      sum_left = {1'b0, diag_a} + {1'b0, diag_b};

      res_left.edge_value   = sum_left[rcef_pkg::PIX_W] ? '1 : sum_left[rcef_pkg::PIX_W-1:0];
      res_left.last_of_run  = ~s1_ctl_ff.has_edge;
      res_left.end_of_frame = 1'b0;

      // Edge column repeats itself: twice the vertical difference.
      res_edge.edge_value   = vert[rcef_pkg::PIX_W-1] ? '1 :
                              {vert[rcef_pkg::PIX_W-2:0], 1'b0};
      res_edge.last_of_run  = 1'b1;
      res_edge.end_of_frame = s1_ctl_ff.last_row;

      push.first  = s1_ctl_ff.has_left ? res_left : res_edge;
      push.second = res_edge;
      push.cnt    = '0;
      if (s1_valid_ff) begin
         push.cnt = {1'b0, s1_ctl_ff.has_left} + {1'b0, s1_ctl_ff.has_edge};
      end
   end

   assign busy = s1_valid_ff;

endmodule

// ----- hw/rtl/rcef_rsp_fifo.sv -----
// Result queue: takes up to two results a cycle, delivers one unless the output is stalled.
`timescale 1ns / 1ps
module rcef_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  rcef_pkg::push_type                  push,
   output logic                                out_valid,
   input  logic                                out_stall,
   output rcef_pkg::rsp_type                   out_data,
   output logic [rcef_pkg::FIFO_CNT_W-1:0]     count
);

   rcef_pkg::rsp_type                   slots [rcef_pkg::FIFO_DEPTH];
   logic [rcef_pkg::FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rcef_pkg::FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rcef_pkg::FIFO_CNT_W-1:0]     count_ff, count_in;
   logic [rcef_pkg::FIFO_PTR_W-1:0]     wr_ptr_next;
   logic                                pop;

   assign out_valid   = (count_ff != '0);
   assign pop         = out_valid & ~out_stall;
   assign wr_ptr_next = wr_ptr_ff + rcef_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rcef_pkg::FIFO_PTR_W'(push.cnt);
      rd_ptr_in = rd_ptr_ff + rcef_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + rcef_pkg::FIFO_CNT_W'(push.cnt)
                  - rcef_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         slots[wr_ptr_ff] <= push.first;
      end
      if (push.cnt == 2'd2) begin
         slots[wr_ptr_next] <= push.second;
      end
   end

   assign out_data = slots[rd_ptr_ff];
   assign count    = count_ff;

endmodule

// ----- hw/rtl/roberts_cross_edge_filter.sv -----
// Roberts cross edge filter top level: registers, counters, line store, pipeline.
`timescale 1ns / 1ps
// Streams an 8-bit grayscale frame in row-major order, one pixel per clock
// unless stalled, and returns |p(i,j)-p(i+1,j+1)| + |p(i,j+1)-p(i+1,j)|
// saturated at 255 for every pixel of rows 0 to height-2; the last pixel of
// each row yields two results (the second uses the replicated edge column),
// the first pixel of a row and all of row 0 yield none. The line store has no
// clearing pass, is ready right after reset and is read and rewritten at the
// same column in the acceptance cycle; results pass the gradient stage
// registers into the 8-entry output queue. req_stall is high in reset, else
// only when the queue could not hold the results of pixels in flight, i.e.
// on result-side stalls. Width and height are to be written only while idle,
// unenforced by the block, and are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
module roberts_cross_edge_filter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_pixel,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_edge_value,
   output logic                         rsp_last_of_run,
   output logic                         rsp_end_of_frame,

   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [11:0]                  csr_write_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WE    = ((COL_W > rcef_pkg::DIM_W) ? COL_W : rcef_pkg::DIM_W) + 2;
   localparam int HE    = ((ROW_W > rcef_pkg::DIM_W) ? ROW_W : rcef_pkg::DIM_W) + 2;
   localparam logic [WE-1:0] MAX_W_C = WE'(MAX_WIDTH);
   localparam logic [HE-1:0] MAX_H_C = HE'(MAX_HEIGHT);
   localparam int SUM_W = rcef_pkg::FIFO_CNT_W + 1;

   logic [rcef_pkg::DIM_W-1:0] width_ff, width_in;
   logic [rcef_pkg::DIM_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [ROW_W-1:0]           row_ff, row_in;

   logic [WE-1:0]              width_ext, width_last;
   logic [HE-1:0]              height_ext, height_last;
   logic                       last_col, last_row, accept;
   rcef_pkg::ctl_type          ctl;
   logic [rcef_pkg::PIX_W-1:0] up_pix;
   logic                       grad_busy;
   rcef_pkg::push_type         push;
   rcef_pkg::rsp_type          rsp_data;
   logic [rcef_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic [SUM_W-1:0]           need;

   // Configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rcef_pkg::REG_IMAGE_WIDTH:  width_in  = csr_write_data;
            rcef_pkg::REG_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rcef_pkg::RESET_WIDTH;
         height_ff <= rcef_pkg::RESET_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Clamped last column / last row index
   always_comb begin
      width_ext  = WE'(width_ff);
      height_ext = HE'(height_ff);
      if (width_ext < WE'(2))       width_last = WE'(1);
      else if (width_ext > MAX_W_C) width_last = MAX_W_C - WE'(1);
      else                          width_last = width_ext - WE'(1);
      if (height_ext < HE'(2))       height_last = HE'(1);
      else if (height_ext > MAX_H_C) height_last = MAX_H_C - HE'(1);
      else                           height_last = height_ext - HE'(1);
   end

   assign last_col = (WE'(col_ff) >= width_last);
   assign last_row = (HE'(row_ff) >= height_last);

   // Room for two results from the pixel in flight and two from this one.
   assign need = SUM_W'(fifo_count) + (grad_busy ? SUM_W'(2) : SUM_W'(0)) + SUM_W'(2);
   assign req_stall = reset | (need > SUM_W'(rcef_pkg::FIFO_DEPTH));
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      ctl.has_left = (row_ff != '0) & (col_ff != '0);
      ctl.has_edge = (row_ff != '0) & last_col;
      ctl.last_row = last_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   rcef_line_buf #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (COL_W)
   ) u_line_buf (
      .clock   (clock),
      .enable  (accept),
      .addr    (col_ff),
      .wr_data (req_pixel),
      .rd_data (up_pix)
   );

   rcef_grad u_grad (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_pix   (req_pixel),
      .in_ctl   (ctl),
      .up_pix   (up_pix),
      .busy     (grad_busy),
      .push     (push)
   );

   rcef_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   assign rsp_edge_value   = rsp_data.edge_value;
   assign rsp_last_of_run  = rsp_data.last_of_run;
   assign rsp_end_of_frame = rsp_data.end_of_frame;

endmodule

// ----- hw/rtl/rcef_checker.sv -----
// Port-level checker for the Roberts cross edge filter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rcef_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_edge_value,
   input logic       rsp_last_of_run,
   input logic       rsp_end_of_frame
);

   `ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_edge_value) && $stable(rsp_last_of_run) && $stable(rsp_end_of_frame))
   `ASSERT_IMPLY(eof_ends_run, clock, reset, rsp_valid && rsp_end_of_frame, rsp_last_of_run)
   `ASSERT_NEXT_ALWAYS(empty_after_reset, clock, reset, !rsp_valid)
   `ASSERT_IMPLY(rsp_follows_transfer, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2))

endmodule

bind roberts_cross_edge_filter rcef_checker u_rcef_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_edge_value   (rsp_edge_value),
   .rsp_last_of_run  (rsp_last_of_run),
   .rsp_end_of_frame (rsp_end_of_frame)
);

// ----- test/tb_roberts_cross_edge_filter.sv -----
// Self-checking testbench for the Roberts cross edge filter: line-store predictor and scoreboard.
`timescale 1ns / 1ps
module tb_roberts_cross_edge_filter;

   localparam int MAX_W = 2048;
   localparam int MAX_H = 2048;
   localparam int CLK_PERIOD = 4;
   localparam int LIMIT_CYCLES = 800_000;

   // Predicts the edge results of the pixel stream and checks them in order.
   class edge_scoreboard;
      logic [7:0]  line_store [MAX_W];
      logic [7:0]  upper_left;
      logic [7:0]  lower_left;
      int unsigned col;
      int unsigned row;
      logic [11:0] width_reg;
      logic [11:0] height_reg;
      rcef_pkg::rsp_type expected_q [$];
      int          mismatches;

      function new();
         foreach (line_store[i]) line_store[i] = 8'd0;
         upper_left = 8'd0;
         lower_left = 8'd0;
         col = 0;
         row = 0;
         width_reg = rcef_pkg::RESET_WIDTH;
         height_reg = rcef_pkg::RESET_HEIGHT;
         mismatches = 0;
      endfunction

      function int unsigned clamp_dim(logic [11:0] v, int unsigned hi);
         if (v < 2) return 2;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned eff_width();
         return clamp_dim(width_reg, MAX_W);
      endfunction

      function int unsigned pixel_distance(logic [7:0] a, logic [7:0] b);
         return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
      endfunction

      function logic [7:0] saturate(int unsigned s);
         return (s > 255) ? 8'hFF : s[7:0];
      endfunction

      function void set_reg(logic idx, logic [11:0] v);
         if (idx == rcef_pkg::REG_IMAGE_WIDTH) width_reg = v;
         else height_reg = v;
      endfunction

      // Called for every accepted pixel transfer.
      function void note_pixel(logic [7:0] cur);
         int unsigned w;
         int unsigned h;
         logic [7:0]  up;
         logic        last_col;
         logic        last_row;
         rcef_pkg::rsp_type r;
         w = eff_width();
         h = clamp_dim(height_reg, MAX_H);
         last_col = (col >= w - 1);
         last_row = (row >= h - 1);
         up = (col < MAX_W) ? line_store[col] : 8'd0;
         if (row >= 1) begin
            if (col >= 1) begin
               r.edge_value = saturate(pixel_distance(upper_left, cur) +
                                       pixel_distance(up, lower_left));
               r.last_of_run = ~last_col;
               r.end_of_frame = 1'b0;
               expected_q.push_back(r);
            end
            // edge column replicated: both diagonals collapse onto the same pair
            if (last_col) begin
               r.edge_value = saturate(2 * pixel_distance(up, cur));
               r.last_of_run = 1'b1;
               r.end_of_frame = last_row;
               expected_q.push_back(r);
            end
         end
         if (col < MAX_W) line_store[col] = cur;
         upper_left = up;
         lower_left = cur;
         if (last_col) begin
            col = 0;
            row = last_row ? 0 : row + 1;
         end else begin
            col = col + 1;
         end
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_result(logic [7:0] ev, logic lor, logic eof);
         rcef_pkg::rsp_type exp_r;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: edge_value=%0d", ev));
            return;
         end
         exp_r = expected_q.pop_front();
         if (ev !== exp_r.edge_value)
            report_mismatch($sformatf("edge_value %0d, want %0d", ev, exp_r.edge_value));
         if (lor !== exp_r.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b", lor, exp_r.last_of_run));
         if (eof !== exp_r.end_of_frame)
            report_mismatch($sformatf("end_of_frame %0b, want %0b", eof, exp_r.end_of_frame));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_edge_value;
   logic        rsp_last_of_run;
   logic        rsp_end_of_frame;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [11:0] csr_write_data = 12'd0;

   edge_scoreboard sb = new();
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   int unsigned    pixels_sent = 0;

   roberts_cross_edge_filter #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_edge_value   (rsp_edge_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_edge_value, rsp_last_of_run, rsp_end_of_frame);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [7:0] p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(p);
      pixels_sent++;
   endtask

   task automatic send_pixels(input int unsigned n);
      repeat (n) send_pixel(pick_pixel());
   endtask

   // Hold the sender until every pending result is out, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [11:0] val);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic finish_frame();
      while (sb.col != 0 || sb.row != 0) send_pixel(pick_pixel());
   endtask

   task automatic new_geometry();
      logic [11:0] w;
      logic [11:0] h;
      w = ($urandom_range(9) == 0) ? 12'($urandom_range(0, 64)) : 12'($urandom_range(2, 10));
      h = ($urandom_range(9) == 0) ? 12'($urandom_range(0, 8)) : 12'($urandom_range(2, 5));
      write_reg(rcef_pkg::REG_IMAGE_WIDTH, w);
      write_reg(rcef_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   // Mid-frame change. Width only grows in row 0, so no unwritten line-store
   // entry is ever read.
   task automatic retune_mid_frame();
      logic [11:0] v;
      if ($urandom_range(1)) begin
         write_reg(rcef_pkg::REG_IMAGE_HEIGHT, 12'($urandom_range(0, 6)));
      end else begin
         v = 12'($urandom_range(0, 12));
         if (sb.row != 0 && sb.clamp_dim(v, MAX_W) > sb.eff_width())
            v = 12'($urandom_range(0, sb.eff_width()));
         write_reg(rcef_pkg::REG_IMAGE_WIDTH, v);
      end
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned stop_at;
      stop_at = pixels_sent + count;
      while (pixels_sent < stop_at) begin
         case ($urandom_range(7))
            0: retune_mid_frame();
            1, 2: begin
               finish_frame();
               new_geometry();
            end
            default: send_pixels($urandom_range(1, 30));
         endcase
      end
      finish_frame();
   endtask

   initial begin
      logic [7:0] corner_pixels [$];
      corner_pixels = '{8'd0, 8'd255, 8'd0, 8'd255,
                        8'd255, 8'd0, 8'd255, 8'd255,
                        8'd128, 8'd128, 8'd128, 8'd128};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 32;
      recv_stall_pct = 52;
      // reset geometry: first row of 640 and the start of the second
      send_pixels(645);
      // shrink below range mid-row: column and row counters are at or past the new ends
      write_reg(rcef_pkg::REG_IMAGE_WIDTH, 12'd1);
      write_reg(rcef_pkg::REG_IMAGE_HEIGHT, 12'd0);
      send_pixels(1);

      // 2x2 frames: saturated sum, saturated edge, flat image
      write_reg(rcef_pkg::REG_IMAGE_WIDTH, 12'd2);
      write_reg(rcef_pkg::REG_IMAGE_HEIGHT, 12'd2);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      // 3x2 vertical stripes: interior column plus edge column
      write_reg(rcef_pkg::REG_IMAGE_WIDTH, 12'd3);
      foreach (corner_pixels[i]) if (i < 6) send_pixel((i % 2 == (i / 3)) ? 8'd255 : 8'd0);

      random_phase(230);
      send_idle_pct = 52;
      recv_stall_pct = 32;
      random_phase(230);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(230);

      // all-ones geometry clamps to the maximum; row 0 is cut short by a shrink
      write_reg(rcef_pkg::REG_IMAGE_WIDTH, 12'hFFF);
      write_reg(rcef_pkg::REG_IMAGE_HEIGHT, 12'hFFF);
      send_pixels(20);
      write_reg(rcef_pkg::REG_IMAGE_WIDTH, 12'd3);
      write_reg(rcef_pkg::REG_IMAGE_HEIGHT, 12'd2);
      finish_frame();

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0)
         $display("roberts_cross_edge_filter verification clean");
      else
         $display("roberts_cross_edge_filter verification failed");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("roberts_cross_edge_filter verification failed");
      $finish;
   end

endmodule
